// ----- rtl/core/sample_map_smooth_hysteresis_core_defines.svh -----
// Assertion macros shared by the sample mapper RTL.
// No dependencies; the including module must have signals named clock and reset.
`ifndef SAMPLE_MAP_SMOOTH_HYSTERESIS_CORE_DEFINES_SVH
`define SAMPLE_MAP_SMOOTH_HYSTERESIS_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// property checked outside reset
`define SMSH_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("%m: assertion failed");
// property checked on every edge, reset included
`define SMSH_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("%m: assertion failed");
`else
`define SMSH_ASSERT(label, prop)
`define SMSH_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ----- rtl/core/smsh_pkg.sv -----
// Package of the sample mapper: widths, fixed-point constants, state and register codes,
// divider control/status structs and the saturation helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smsh_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int SAMPLE_W    = 16;
   localparam int VAL_W       = 24;
   localparam int WEIGHT_W    = 17;
   localparam int WEIGHT_FRAC = 16;
   localparam int BAND_W      = 23;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 5;

   // |sample - low| fits SAMPLE_W unsigned bits; dividend is that shifted up by FRAC_BITS
   localparam int DIVISOR_W  = SAMPLE_W;
   localparam int DIVIDEND_W = SAMPLE_W + FRAC_BITS;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
   localparam int QS_W       = DIVIDEND_W + 1;
   localparam int SAT_W      = 48;

   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic signed [VAL_W-1:0] ONE_VAL =
      (FRAC_BITS >= VAL_W - 1) ? VAL_MAX : VAL_W'(1 << FRAC_BITS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_FIX,
      S_MAP,
      S_MUL,
      S_AVG,
      S_HYS,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      CSR_INPUT_LOW,
      CSR_INPUT_HIGH,
      CSR_WRAP_ENABLE,
      CSR_CLAMP_ENABLE,
      CSR_SMOOTHING_ENABLE,
      CSR_SMOOTHING_WEIGHT,
      CSR_HYSTERESIS_ENABLE,
      CSR_HYSTERESIS_BAND
   } csr_index_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic rem_nonzero;
   } div_stat_type;

   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SAT_W-1:0] x);
      logic signed [VAL_W-1:0] r;
      if (x > SAT_W'(VAL_MAX)) begin
         r = VAL_MAX;
      end else if (x < SAT_W'(VAL_MIN)) begin
         r = VAL_MIN;
      end else begin
         r = x[VAL_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/smsh_req_if.sv -----
// Input channel of the sample mapper: one raw sample per transfer.
// Depends on smsh_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface smsh_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [smsh_pkg::SAMPLE_W-1:0]   raw_sample;

   modport source (output valid, output raw_sample, input ready);
   modport sink   (input valid, input raw_sample, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/smsh_rsp_if.sv -----
// Result channel of the sample mapper: mapped value, level and saturation flag.
// Depends on smsh_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface smsh_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [smsh_pkg::VAL_W-1:0]   smoothed_value;
   logic signed [smsh_pkg::VAL_W-1:0]   level_value;
   logic                                saturated;

   modport source (output valid, output smoothed_value, output level_value,
                   output saturated, input ready);
   modport sink   (input valid, input smoothed_value, input level_value,
                   input saturated, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/smsh_divider.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on smsh_pkg (widths, control and status structs).
`timescale 1ns / 1ps
`default_nettype none

module smsh_divider (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire smsh_pkg::div_ctrl_type               ctrl,
   input  wire logic [smsh_pkg::DIVIDEND_W-1:0]      dividend,
   input  wire logic [smsh_pkg::DIVISOR_W-1:0]       divisor,
   output      logic [smsh_pkg::DIVIDEND_W-1:0]      quotient,
   output      smsh_pkg::div_stat_type               status
);

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [smsh_pkg::DIV_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [smsh_pkg::DIVIDEND_W-1:0]      quo_ff, quo_in;
   logic [smsh_pkg::DIVISOR_W-1:0]       rem_ff, rem_in;
   logic [smsh_pkg::DIVISOR_W-1:0]       dsr_ff, dsr_in;
   logic [smsh_pkg::DIVISOR_W:0]         trial;
   logic [smsh_pkg::DIVISOR_W+1:0]       sub;

   // shift the next dividend bit into the partial remainder and try the subtract
   assign trial = {rem_ff, quo_ff[smsh_pkg::DIVIDEND_W-1]};
   assign sub   = {1'b0, trial} - {2'b00, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = smsh_pkg::DIV_CNT_W'(smsh_pkg::DIVIDEND_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (!sub[smsh_pkg::DIVISOR_W+1]) begin
            rem_in = sub[smsh_pkg::DIVISOR_W-1:0];
         end else begin
            rem_in = trial[smsh_pkg::DIVISOR_W-1:0];
         end
         quo_in = {quo_ff[smsh_pkg::DIVIDEND_W-2:0], ~sub[smsh_pkg::DIVISOR_W+1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient           = quo_ff;
   assign status.busy        = busy_ff;
   assign status.done        = done_ff;
   assign status.rem_nonzero = (rem_ff != '0);

endmodule

`default_nettype wire

// ----- rtl/core/sample_map_smooth_hysteresis_core.sv -----
// Sample mapper top level: maps a raw sample to a unit range, wraps or clamps,
// smooths with an EMA and applies two-level hysteresis.
//
// Usage:
//   req_bus  : one signed 16-bit raw_sample per transfer (valid/ready).
//   rsp_bus  : one result per sample: smoothed_value, level_value (Q7.16), saturated.
//   csr_*    : APB-style register port, register i at byte address 4*i, pready tied high.
//              The user must change registers only while no sample is in flight;
//              the block itself does not enforce this.
//   The quotient comes from a radix-2 divider that retires one bit per cycle,
//   FRAC_BITS+16 bits in all. An accepted sample passes through S_DIV, S_FIX, S_MAP,
//   S_MUL, S_AVG, S_HYS and S_DONE; the next sample is taken only after the result
//   is loaded, so no new sample is accepted while one is in flight. With equal input
//   bounds the divider is skipped and S_DIV is not entered.
//   The multiply for the average has a step of its own, S_MUL.
// Reset (synchronous, active high): registers take their documented defaults, the
//   average is cleared and unprimed, the held level is low, no result is pending.
// Stall: a finished result waits in the output register; the sequencer holds in its
//   last step until that register is free, and a new sample is taken as soon as the
//   result is loaded, even if the receiver has not yet taken it.
`timescale 1ns / 1ps
`default_nettype none
`include "sample_map_smooth_hysteresis_core_defines.svh"

module sample_map_smooth_hysteresis_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   smsh_req_if.sink                                req_bus,
   smsh_rsp_if.source                              rsp_bus,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [smsh_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [smsh_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output      logic [smsh_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output      logic                               csr_pready
);

   localparam int VW1    = smsh_pkg::VAL_W + 1;
   localparam int PROD_W = smsh_pkg::WEIGHT_W + 1 + VW1;

   // configuration
   logic signed [smsh_pkg::SAMPLE_W-1:0] low_ff, low_in;
   logic signed [smsh_pkg::SAMPLE_W-1:0] high_ff, high_in;
   logic                                 wrap_ff, wrap_in;
   logic                                 clamp_ff, clamp_in;
   logic                                 smooth_ff, smooth_in;
   logic [smsh_pkg::WEIGHT_W-1:0]        weight_ff, weight_in;
   logic                                 hyst_ff, hyst_in;
   logic [smsh_pkg::BAND_W-1:0]          band_ff, band_in;
   logic                                 csr_write;
   smsh_pkg::csr_index_type              csr_index;

   // sequencer and datapath
   smsh_pkg::state_type                  state_ff, state_in;
   logic                                 neg_ff, neg_in;
   logic                                 den_zero_ff, den_zero_in;
   logic signed [smsh_pkg::QS_W-1:0]     qs_ff, qs_in;
   logic signed [smsh_pkg::VAL_W-1:0]    val_ff, val_in;
   logic                                 sat_ff, sat_in;
   logic signed [PROD_W-1:0]             prod_ff, prod_in;
   logic signed [smsh_pkg::VAL_W-1:0]    avg_ff, avg_in;
   logic                                 primed_ff, primed_in;
   logic                                 held_ff, held_in;
   logic signed [smsh_pkg::VAL_W-1:0]    level_ff, level_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [smsh_pkg::VAL_W-1:0]    rsp_smoothed_ff, rsp_smoothed_in;
   logic signed [smsh_pkg::VAL_W-1:0]    rsp_level_ff, rsp_level_in;
   logic                                 rsp_sat_ff, rsp_sat_in;
   logic                                 rsp_load;

   // combinational helpers
   logic signed [smsh_pkg::SAMPLE_W:0]   diff17;
   logic signed [smsh_pkg::SAMPLE_W:0]   den17;
   logic signed [smsh_pkg::SAMPLE_W:0]   diff_abs;
   logic signed [smsh_pkg::SAMPLE_W:0]   den_abs;
   logic [smsh_pkg::DIVIDEND_W-1:0]      dividend;
   logic [smsh_pkg::DIVISOR_W-1:0]       divisor;
   logic [smsh_pkg::DIVIDEND_W-1:0]      quotient;
   logic signed [smsh_pkg::QS_W-1:0]     uq_ext;
   logic signed [smsh_pkg::QS_W-1:0]     frac_ext;
   logic signed [smsh_pkg::VAL_W-1:0]    mapped;
   logic signed [VW1-1:0]                avg_diff;
   logic signed [smsh_pkg::SAT_W-1:0]    avg_sum;
   logic signed [smsh_pkg::VAL_W-1:0]    avg_new;
   logic signed [smsh_pkg::VAL_W-1:0]    prev_level;
   logic signed [VW1-1:0]                hyst_diff;
   logic signed [VW1-1:0]                hyst_abs;
   logic                                 held_next;

   smsh_pkg::div_ctrl_type               div_ctrl;
   smsh_pkg::div_stat_type               div_stat;

   smsh_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (dividend),
      .divisor  (divisor),
      .quotient (quotient),
      .status   (div_stat)
   );

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = smsh_pkg::csr_index_type'(csr_paddr[4:2]);

   always_comb begin
      low_in    = low_ff;
      high_in   = high_ff;
      wrap_in   = wrap_ff;
      clamp_in  = clamp_ff;
      smooth_in = smooth_ff;
      weight_in = weight_ff;
      hyst_in   = hyst_ff;
      band_in   = band_ff;
      if (csr_write) begin
         case (csr_index)
            smsh_pkg::CSR_INPUT_LOW:         low_in    = csr_pwdata[smsh_pkg::SAMPLE_W-1:0];
            smsh_pkg::CSR_INPUT_HIGH:        high_in   = csr_pwdata[smsh_pkg::SAMPLE_W-1:0];
            smsh_pkg::CSR_WRAP_ENABLE:       wrap_in   = csr_pwdata[0];
            smsh_pkg::CSR_CLAMP_ENABLE:      clamp_in  = csr_pwdata[0];
            smsh_pkg::CSR_SMOOTHING_ENABLE:  smooth_in = csr_pwdata[0];
            smsh_pkg::CSR_SMOOTHING_WEIGHT:  weight_in = csr_pwdata[smsh_pkg::WEIGHT_W-1:0];
            smsh_pkg::CSR_HYSTERESIS_ENABLE: hyst_in   = csr_pwdata[0];
            smsh_pkg::CSR_HYSTERESIS_BAND:   band_in   = csr_pwdata[smsh_pkg::BAND_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         smsh_pkg::CSR_INPUT_LOW:
            csr_prdata = smsh_pkg::CSR_DATA_W'(unsigned'(low_ff));
         smsh_pkg::CSR_INPUT_HIGH:
            csr_prdata = smsh_pkg::CSR_DATA_W'(unsigned'(high_ff));
         smsh_pkg::CSR_WRAP_ENABLE:       csr_prdata = smsh_pkg::CSR_DATA_W'(wrap_ff);
         smsh_pkg::CSR_CLAMP_ENABLE:      csr_prdata = smsh_pkg::CSR_DATA_W'(clamp_ff);
         smsh_pkg::CSR_SMOOTHING_ENABLE:  csr_prdata = smsh_pkg::CSR_DATA_W'(smooth_ff);
         smsh_pkg::CSR_SMOOTHING_WEIGHT:  csr_prdata = smsh_pkg::CSR_DATA_W'(weight_ff);
         smsh_pkg::CSR_HYSTERESIS_ENABLE: csr_prdata = smsh_pkg::CSR_DATA_W'(hyst_ff);
         smsh_pkg::CSR_HYSTERESIS_BAND:   csr_prdata = smsh_pkg::CSR_DATA_W'(band_ff);
         default:                         csr_prdata = '0;
      endcase
   end

   // ---------------- datapath helpers ----------------
   assign diff17   = (smsh_pkg::SAMPLE_W+1)'(req_bus.raw_sample) -
                     (smsh_pkg::SAMPLE_W+1)'(low_ff);
   assign den17    = (smsh_pkg::SAMPLE_W+1)'(high_ff) - (smsh_pkg::SAMPLE_W+1)'(low_ff);
   assign diff_abs = diff17[smsh_pkg::SAMPLE_W] ? -diff17 : diff17;
   assign den_abs  = den17[smsh_pkg::SAMPLE_W] ? -den17 : den17;
   assign dividend = {diff_abs[smsh_pkg::SAMPLE_W-1:0], {smsh_pkg::FRAC_BITS{1'b0}}};
   assign divisor  = den_abs[smsh_pkg::DIVISOR_W-1:0];

   assign div_ctrl.start = (state_ff == smsh_pkg::S_IDLE) && req_bus.valid && (den17 != '0);

   // floor quotient: a negative inexact result is one below the truncated one
   assign uq_ext   = smsh_pkg::QS_W'(quotient);
   assign frac_ext = smsh_pkg::QS_W'(qs_ff[smsh_pkg::FRAC_BITS-1:0]);

   always_comb begin
      mapped = smsh_pkg::sat_val(smsh_pkg::SAT_W'(qs_ff));
      if (clamp_ff) begin
         if (mapped < 0) begin
            mapped = '0;
         end else if (mapped > smsh_pkg::ONE_VAL) begin
            mapped = smsh_pkg::ONE_VAL;
         end
      end
      if (wrap_ff) begin
         mapped = smsh_pkg::sat_val(smsh_pkg::SAT_W'(frac_ext));
      end
   end

   assign avg_diff = VW1'(val_ff) - VW1'(avg_ff);
   // arithmetic shift gives the floor of the weighted step
   assign avg_sum  = smsh_pkg::SAT_W'(avg_ff) +
                     smsh_pkg::SAT_W'($signed(prod_ff[PROD_W-1:smsh_pkg::WEIGHT_FRAC]));
   assign avg_new  = smsh_pkg::sat_val(avg_sum);

   assign prev_level = held_ff ? smsh_pkg::ONE_VAL : '0;
   assign hyst_diff  = VW1'(val_ff) - VW1'(prev_level);
   assign hyst_abs   = hyst_diff[VW1-1] ? -hyst_diff : hyst_diff;
   assign held_next  = (val_ff > prev_level);

   assign rsp_load = (state_ff == smsh_pkg::S_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in        = state_ff;
      neg_in          = neg_ff;
      den_zero_in     = den_zero_ff;
      qs_in           = qs_ff;
      val_in          = val_ff;
      sat_in          = sat_ff;
      prod_in         = prod_ff;
      avg_in          = avg_ff;
      primed_in       = primed_ff;
      held_in         = held_ff;
      level_in        = level_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_smoothed_in = rsp_smoothed_ff;
      rsp_level_in    = rsp_level_ff;
      rsp_sat_in      = rsp_sat_ff;
      req_bus.ready   = 1'b0;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         smsh_pkg::S_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               neg_in      = diff17[smsh_pkg::SAMPLE_W] ^ den17[smsh_pkg::SAMPLE_W];
               den_zero_in = (den17 == '0);
               state_in    = (den17 == '0) ? smsh_pkg::S_FIX : smsh_pkg::S_DIV;
            end
         end
         smsh_pkg::S_DIV: begin
            if (div_stat.done) begin
               state_in = smsh_pkg::S_FIX;
            end
         end
         smsh_pkg::S_FIX: begin
            if (den_zero_ff) begin
               qs_in = '0;
            end else if (neg_ff) begin
               qs_in = div_stat.rem_nonzero ? ~uq_ext : -uq_ext;
            end else begin
               qs_in = uq_ext;
            end
            state_in = smsh_pkg::S_MAP;
         end
         smsh_pkg::S_MAP: begin
            sat_in   = (qs_ff > smsh_pkg::QS_W'(smsh_pkg::VAL_MAX)) ||
                       (qs_ff < smsh_pkg::QS_W'(smsh_pkg::VAL_MIN));
            val_in   = mapped;
            state_in = smsh_pkg::S_MUL;
         end
         smsh_pkg::S_MUL: begin
            prod_in  = $signed({1'b0, weight_ff}) * avg_diff;
            state_in = smsh_pkg::S_AVG;
         end
         smsh_pkg::S_AVG: begin
            if (smooth_ff) begin
               if (!primed_ff) begin
                  avg_in    = val_ff;
                  primed_in = 1'b1;
               end else begin
                  avg_in = avg_new;
                  val_in = avg_new;
               end
            end
            state_in = smsh_pkg::S_HYS;
         end
         smsh_pkg::S_HYS: begin
            level_in = val_ff;
            if (hyst_ff) begin
               if (hyst_abs <= VW1'(band_ff)) begin
                  level_in = prev_level;
               end else begin
                  held_in  = held_next;
                  level_in = held_next ? smsh_pkg::ONE_VAL : '0;
               end
            end
            state_in = smsh_pkg::S_DONE;
         end
         smsh_pkg::S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in    = 1'b1;
               rsp_smoothed_in = val_ff;
               rsp_level_in    = level_ff;
               rsp_sat_in      = sat_ff;
               state_in        = smsh_pkg::S_IDLE;
            end
         end
         default: state_in = smsh_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= '0;
         high_ff      <= 16'sd32767;
         wrap_ff      <= 1'b0;
         clamp_ff     <= 1'b1;
         smooth_ff    <= 1'b0;
         weight_ff    <= 17'd16384;
         hyst_ff      <= 1'b0;
         band_ff      <= 23'd6554;
         state_ff     <= smsh_pkg::S_IDLE;
         avg_ff       <= '0;
         primed_ff    <= 1'b0;
         held_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         low_ff       <= low_in;
         high_ff      <= high_in;
         wrap_ff      <= wrap_in;
         clamp_ff     <= clamp_in;
         smooth_ff    <= smooth_in;
         weight_ff    <= weight_in;
         hyst_ff      <= hyst_in;
         band_ff      <= band_in;
         state_ff     <= state_in;
         avg_ff       <= avg_in;
         primed_ff    <= primed_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff          <= neg_in;
      den_zero_ff     <= den_zero_in;
      qs_ff           <= qs_in;
      val_ff          <= val_in;
      sat_ff          <= sat_in;
      prod_ff         <= prod_in;
      level_ff        <= level_in;
      rsp_smoothed_ff <= rsp_smoothed_in;
      rsp_level_ff    <= rsp_level_in;
      rsp_sat_ff      <= rsp_sat_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.smoothed_value = rsp_smoothed_ff;
   assign rsp_bus.level_value    = rsp_level_ff;
   assign rsp_bus.saturated      = rsp_sat_ff;

   // ---------------- checks ----------------
   `SMSH_ASSERT(a_div_start_idle,
      div_ctrl.start |-> (state_ff == smsh_pkg::S_IDLE) && !div_stat.busy)
   `SMSH_ASSERT(a_div_done_in_div, div_stat.done |-> (state_ff == smsh_pkg::S_DIV))
   `SMSH_ASSERT(a_level_passthru,
      (rsp_load && !hyst_ff) |=> (rsp_level_ff == rsp_smoothed_ff))
   `SMSH_ASSERT(a_hold_on_stall,
      ((state_ff == smsh_pkg::S_DONE) && rsp_valid_ff && !rsp_bus.ready)
         |=> (state_ff == smsh_pkg::S_DONE))
   `SMSH_ASSERT_ALWAYS(a_primed_sticky, $fell(primed_ff) |-> $past(reset))

endmodule

`default_nettype wire
